>>> hdl/dfa_wa_pkg.sv
// shared constants, item codes and types of the dfa word acceptor
// no dependencies; imported by the core, the row ram user and the checker
package dfa_wa_pkg;

	// automaton size
	localparam int MAX_STATES = 16;
	localparam int MAX_EVENTS = 16;

	// address and row geometry of the transition store (one row per source state)
	localparam int ST_AW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int EV_AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int ROW_W = MAX_STATES * MAX_EVENTS;
	localparam int POS_W = (ROW_W > 1) ? $clog2(ROW_W) : 1;

	// fixed field widths
	localparam int STATE_W    = 4;
	localparam int EVENT_W    = 4;
	localparam int SYM_W      = 8;
	localparam int COUNT_W    = 5;
	localparam int MASK_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		MODE_LOAD_SYM   = 2'd0,
		MODE_WRITE_BIT  = 2'd1,
		MODE_WORD_SYM   = 2'd2,
		MODE_EMPTY_WORD = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_ACCEPTED    = 2'd0,
		STAT_UNKNOWN_SYM = 2'd1,
		STAT_NO_TRANS    = 2'd2,
		STAT_NOT_FINAL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_NUM_STATES   = 2'd0,
		CFG_NUM_EVENTS   = 2'd1,
		CFG_INIT_STATE   = 2'd2,
		CFG_FINAL_MASK   = 2'd3
	} cfg_idx_t;

endpackage

>>> hdl/dfa_wa_ram.sv
// generic single-write, single-read ram with per-bit write mask and registered read
// write-first: a read of the address being written returns the merged new word
module dfa_wa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [WIDTH-1:0] wmask,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;
	logic [WIDTH-1:0] merged;

	assign merged = (mem_q[waddr] & ~wmask) | (wdata & wmask);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= merged;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= merged;
		end else begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/dfa_word_acceptor_core.sv
// dfa word acceptor top level: input stage, symbol step logic, result register
// depends on dfa_wa_pkg and dfa_wa_ram (transition rows, one per source state)

// The block runs words through a stored deterministic automaton, one symbol per request.
// Load requests fill the 16-slot alphabet and set or clear single transition bits; word
// symbol and empty-word requests step the automaton, and the last symbol of a word (or
// an empty-word request) produces one result: accepted, a status code and the end state.
// A new request is taken every cycle, loads and symbols alike, unless a word end finds
// the result register still held by a stalled result; after its request is accepted, a
// result passes the input stage and then the result register. The step rate rests on
// the transition ram: its read address always follows the next state, so the whole row
// of the state in hand (all events) is already registered when the next symbol arrives;
// the alphabet compare and the next-state priority encode are then combinational.
// Transition rows read as zero until first written (one valid flop per row, no clearing
// pass). Alphabet slots hold no reset value and must be loaded before any word uses them.
// Configuration writes are taken at any time but are meant for idle periods; writing
// initial_state also aborts a word in progress.
module dfa_word_acceptor_core
	import dfa_wa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [EVENT_W-1:0]    event_index,
	input  logic [STATE_W-1:0]    from_state,
	input  logic [STATE_W-1:0]    to_state,
	input  logic                  bit_value,
	input  logic [SYM_W-1:0]      symbol,
	input  logic                  last,

	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accepted,
	output logic [1:0]            status,
	output logic [STATE_W-1:0]    end_state
);

	// configuration registers
	logic [COUNT_W-1:0] num_states_q;
	logic [COUNT_W-1:0] num_events_q;
	logic [STATE_W-1:0] init_state_q;
	logic [MASK_W-1:0]  final_mask_q;

	// input stage
	logic               vld_s1;
	mode_t              mode_s1;
	logic [EVENT_W-1:0] event_s1;
	logic [STATE_W-1:0] from_s1;
	logic [STATE_W-1:0] to_s1;
	logic               bit_s1;
	logic [SYM_W-1:0]   sym_s1;
	logic               last_s1;

	// automaton state
	logic [STATE_W-1:0] cur_q;
	status_t            rej_q;
	logic [SYM_W-1:0]   alpha_q [MAX_EVENTS];
	logic [MAX_STATES-1:0] row_vld_q;
	logic               rd_vld_q;

	// result register
	logic               out_vld_q;
	logic               accepted_q;
	status_t            status_q;
	logic [STATE_W-1:0] end_state_q;

	// handshakes
	logic in_fire;
	logic cfg_wr;
	logic emit_s1;
	logic fire_s1;

	// step logic
	logic               ev_hit;
	logic [EV_AW-1:0]   ev_idx;
	logic               state_in_range;
	logic [ROW_W-1:0]   row_rd;
	logic [MAX_STATES-1:0] col;
	logic               nxt_hit;
	logic [STATE_W-1:0] nxt_idx;
	logic [STATE_W-1:0] cur_adv;
	status_t            rej_adv;
	status_t            verdict;
	logic [STATE_W-1:0] cur_step;
	status_t            rej_step;
	logic [STATE_W-1:0] cur_d;
	status_t            rej_d;

	// transition store access
	logic                  tw_en;
	logic [ST_AW-1:0]      tw_addr;
	logic [POS_W-1:0]      tw_pos;
	logic [ROW_W-1:0]      tw_bit;
	logic [ROW_W-1:0]      tw_mask;
	logic [ROW_W-1:0]      tw_data;
	logic [ST_AW-1:0]      tr_addr;
	logic [MAX_STATES-1:0] row_vld_d;

	// ---------------------------------------------------------------- handshakes
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// only a request that ends a word needs room in the result register
	assign emit_s1 = vld_s1 && ((mode_s1 == MODE_EMPTY_WORD) ||
		((mode_s1 == MODE_WORD_SYM) && last_s1));
	assign fire_s1 = vld_s1 && (!emit_s1 || !out_vld_q || out_ready);
	assign in_ready = !vld_s1 || fire_s1;
	assign in_fire  = in_valid && in_ready;

	// ---------------------------------------------------------------- input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1  <= mode_t'(mode);
			event_s1 <= event_index;
			from_s1  <= from_state;
			to_s1    <= to_state;
			bit_s1   <= bit_value;
			sym_s1   <= symbol;
			last_s1  <= last;
		end
	end

	// ---------------------------------------------------------------- symbol step
	// alphabet lookup: highest slot in use holding the symbol; slots at or above
	// num_events never match, which also covers saturation at MAX_EVENTS
	always_comb begin
		ev_hit = 1'b0;
		ev_idx = '0;
		for (int j = 0; j < MAX_EVENTS; j++) begin
			if ((j < int'(num_events_q)) && (alpha_q[j] == sym_s1)) begin
				ev_hit = 1'b1;
				ev_idx = EV_AW'(j);
			end
		end
	end

	// registered row belongs to cur_q; unwritten rows and states outside the store read empty
	assign state_in_range = int'(cur_q) < MAX_STATES;
	assign col = (rd_vld_q && state_in_range) ?
		row_rd[ev_idx * MAX_STATES +: MAX_STATES] : '0;

	// next state: highest set bit among the states in use
	always_comb begin
		nxt_hit = 1'b0;
		nxt_idx = '0;
		for (int j = 0; j < MAX_STATES; j++) begin
			if ((j < int'(num_states_q)) && col[j]) begin
				nxt_hit = 1'b1;
				nxt_idx = STATE_W'(j);
			end
		end
	end

	always_comb begin
		cur_adv = cur_q;
		rej_adv = rej_q;
		// symbols after a rejection are ignored
		if (vld_s1 && (mode_s1 == MODE_WORD_SYM) && (rej_q == STAT_ACCEPTED)) begin
			if (!ev_hit) begin
				rej_adv = STAT_UNKNOWN_SYM;
			end else if (!nxt_hit) begin
				rej_adv = STAT_NO_TRANS;
			end else begin
				cur_adv = nxt_idx;
			end
		end

		if (rej_adv != STAT_ACCEPTED) begin
			verdict = rej_adv;
		end else if (final_mask_q[cur_adv]) begin
			verdict = STAT_ACCEPTED;
		end else begin
			verdict = STAT_NOT_FINAL;
		end

		// a word end returns to the start state
		if (emit_s1) begin
			cur_step = init_state_q;
			rej_step = STAT_ACCEPTED;
		end else begin
			cur_step = cur_adv;
			rej_step = rej_adv;
		end

		// writing the start state aborts the word in hand
		if (cfg_wr && (cfg_idx_t'(cfg_index) == CFG_INIT_STATE)) begin
			cur_d = cfg_data[STATE_W-1:0];
			rej_d = STAT_ACCEPTED;
		end else if (fire_s1) begin
			cur_d = cur_step;
			rej_d = rej_step;
		end else begin
			cur_d = cur_q;
			rej_d = rej_q;
		end
	end

	// ---------------------------------------------------------------- state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= COUNT_W'(1);
			num_events_q <= '0;
			init_state_q <= '0;
			final_mask_q <= '0;
			cur_q        <= '0;
			rej_q        <= STAT_ACCEPTED;
			row_vld_q    <= '0;
			rd_vld_q     <= 1'b0;
		end else begin
			cur_q     <= cur_d;
			rej_q     <= rej_d;
			row_vld_q <= row_vld_d;
			rd_vld_q  <= row_vld_d[tr_addr];
			if (cfg_wr) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_NUM_STATES: num_states_q <= cfg_data[COUNT_W-1:0];
					CFG_NUM_EVENTS: num_events_q <= cfg_data[COUNT_W-1:0];
					CFG_INIT_STATE: init_state_q <= cfg_data[STATE_W-1:0];
					CFG_FINAL_MASK: final_mask_q <= cfg_data[MASK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// alphabet slots: no reset, loaded by requests
	always_ff @(posedge clk) begin
		if (fire_s1 && (mode_s1 == MODE_LOAD_SYM) && (int'(event_s1) < MAX_EVENTS)) begin
			alpha_q[EV_AW'(event_s1)] <= sym_s1;
		end
	end

	// ---------------------------------------------------------------- transition store
	assign tw_en = fire_s1 && (mode_s1 == MODE_WRITE_BIT) &&
		(int'(event_s1) < MAX_EVENTS) && (int'(from_s1) < MAX_STATES) &&
		(int'(to_s1) < MAX_STATES);
	assign tw_addr = ST_AW'(from_s1);
	assign tw_pos  = POS_W'(event_s1) * POS_W'(MAX_STATES) + POS_W'(to_s1);
	assign tw_bit  = ROW_W'(1) << tw_pos;
	// first write to a row replaces the whole row so its other bits start at zero
	assign tw_mask = row_vld_q[tw_addr] ? tw_bit : '1;
	assign tw_data = bit_s1 ? tw_bit : '0;

	always_comb begin
		row_vld_d = row_vld_q;
		if (tw_en) begin
			row_vld_d[tw_addr] = 1'b1;
		end
	end

	// read address tracks the next state so its row is ready for the next symbol
	assign tr_addr = ST_AW'(cur_d);

	dfa_wa_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_STATES)
	) u_trans_ram (
		.clk   (clk),
		.we    (tw_en),
		.waddr (tw_addr),
		.wdata (tw_data),
		.wmask (tw_mask),
		.raddr (tr_addr),
		.rdata (row_rd)
	);

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire_s1 && emit_s1) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit_s1) begin
			accepted_q  <= (verdict == STAT_ACCEPTED);
			status_q    <= verdict;
			end_state_q <= cur_adv;
		end
	end

	assign out_valid = out_vld_q;
	assign accepted  = accepted_q;
	assign status    = status_q;
	assign end_state = end_state_q;

endmodule

>>> hdl/dfa_wa_checker.sv
// port-level checks of the dfa word acceptor, bound to its top level
// depends on dfa_wa_pkg for the status codes
module dfa_wa_checker
	import dfa_wa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               accepted,
	input logic [1:0]         status,
	input logic [STATE_W-1:0] end_state
);

	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(accepted) && $stable(status) && $stable(end_state))
		else $error("result payload changed while stalled");

	// the accept flag agrees with the status code
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accepted == (status == STAT_ACCEPTED)))
		else $error("accepted disagrees with status");

	// with the result register empty nothing can hold back a request
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request stalled with empty result register");

endmodule

bind dfa_word_acceptor_core dfa_wa_checker u_dfa_wa_checker (.*);
